### rtl/bru_pkg.sv
// Package for the byte-map run-length unpacker: word types, codes and constants.
// Shared by bru_front, bru_back and bytemap_rle_unpacker_top; depends on nothing.
package bru_pkg;

   localparam int unsigned COUNT_WIDTH_DEFAULT = 24;
   localparam int unsigned QUEUE_DEPTH         = 4;
   localparam int unsigned LENGTH_WIDTH        = 24;

   localparam logic [7:0]              COPY_FLAG_VALUE     = 8'd1;
   localparam logic [2:0]              CODES_PER_CTRL      = 3'd4;
   localparam logic [1:0]              LONG_LENGTH_BYTES   = 2'd3;
   localparam logic [LENGTH_WIDTH-1:0] OUTPUT_LENGTH_RESET = 24'd1;

   localparam logic [1:0] CODE_ZERO    = 2'd0;
   localparam logic [1:0] CODE_REPEAT  = 2'd1;
   localparam logic [1:0] CODE_RUN     = 2'd2;
   localparam logic [1:0] CODE_LITERAL = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_req;
   } bru_req_type;

   typedef struct packed {
      logic [7:0]              value;
      logic [LENGTH_WIDTH-1:0] count;
      logic                    buffer_done;
      logic                    item_last;
   } bru_rsp_type;

   typedef enum logic [1:0] {
      KIND_DATA,
      KIND_START_COPY,
      KIND_START_PACKED
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } bru_word_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CTRL,
      PH_VALUE,
      PH_LEN,
      PH_LONG,
      PH_LIT,
      PH_COPY,
      PH_RUN
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [2:0] left;
      logic [7:0] shift;
      logic       take;
      logic       pend_run;
      logic       wait_set;
   } resolve_type;

   // Decides how the code loop continues: stop, fetch a control byte, keep emitting
   // single bytes, or take a run or literal code and wait for its data.
   function automatic resolve_type bru_resolve(input logic rem_zero,
                                               input logic [2:0] left,
                                               input logic [7:0] shift);
      resolve_type r;
      logic [1:0]  code;
      code       = shift[1:0];
      r.phase    = PH_RUN;
      r.left     = left;
      r.shift    = shift;
      r.take     = 1'b0;
      r.pend_run = 1'b0;
      r.wait_set = 1'b0;
      if (rem_zero) begin
         r.phase = PH_IDLE;
      end else if (left == 3'd0) begin
         r.phase = PH_CTRL;
      end else if (code == CODE_ZERO || code == CODE_REPEAT) begin
         r.phase = PH_RUN;
      end else begin
         r.take     = 1'b1;
         r.pend_run = (code == CODE_RUN);
         r.left     = left - 3'd1;
         r.shift    = {2'b00, shift[7:2]};
         if (left == 3'd1) begin
            r.wait_set = 1'b1;
            r.phase    = PH_CTRL;
         end else begin
            r.phase = (code == CODE_RUN) ? PH_VALUE : PH_LIT;
         end
      end
      return r;
   endfunction

endpackage

### rtl/bytemap_rle_unpacker_top.sv
// Top level of the byte-map run-length unpacker: length register, front queue and back end.
// Depends on bru_pkg, bru_front and bru_back.
//
// Each word on the req channel is one byte of a compressed buffer; start_req marks the flag
// byte that opens a buffer. The rsp channel returns value/count records; item_last marks the
// final record caused by an input byte and buffer_done the record that covers output_length.
// The csr channel writes output_length, which is always ready and is taken up by the next
// flag byte; it should only be written while the block is idle.
// Accepted words enter a four-word queue; the back end takes one word per cycle unless it is
// stepping through codes or the result is blocked, and emits at most one record per cycle into
// the result register, which drives rsp. The code loop handles one code per cycle; each zero
// or repeat code that a word's decoding reaches gives a single-byte record and holds the back
// end from the queue. While rsp_stall is high and a record waits, the result register holds,
// the back end pauses and the queue fills; req_stall rises once the queue is full.
// Synchronous reset empties the queue and the result register, returns the parser to waiting
// for a flag byte and sets output_length to 1.
module bytemap_rle_unpacker_top #(
   parameter int unsigned COUNT_WIDTH = bru_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  bru_pkg::bru_req_type             req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output bru_pkg::bru_rsp_type             rsp_word,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bru_pkg::LENGTH_WIDTH-1:0] csr_data
);
   import bru_pkg::*;

   logic [LENGTH_WIDTH-1:0] output_length_ff, output_length_in;
   logic                    word_valid;
   bru_word_type            word;
   logic                    word_pop;

   assign csr_ready        = 1'b1;
   assign output_length_in = (csr_valid && csr_ready) ? csr_data : output_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         output_length_ff <= OUTPUT_LENGTH_RESET;
      end else begin
         output_length_ff <= output_length_in;
      end
   end

   bru_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .word_valid (word_valid),
      .word       (word),
      .word_pop   (word_pop)
   );

   bru_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .output_length (output_length_ff),
      .word_valid    (word_valid),
      .word          (word),
      .word_pop      (word_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_word)
   );

   // A record that completes the buffer ends decoding, so it is always the last for its byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.buffer_done |-> rsp_word.item_last)
      else $error("buffer_done record not marked as last for its byte");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.count != '0)
      else $error("record with zero count emitted");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> word_valid)
      else $error("input stalled while the queue is empty");

   assert property (@(posedge clock) disable iff (reset)
      word_pop |-> word_valid && !(rsp_valid && rsp_stall))
      else $error("word taken from the queue while it is empty or the result is blocked");

endmodule

### rtl/bru_front.sv
// Front end of the unpacker: accepts input words, classifies flag bytes and queues them.
// Depends on bru_pkg.
module bru_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bru_pkg::bru_req_type   req_word,
   output logic                   word_valid,
   output bru_pkg::bru_word_type  word,
   input  logic                   word_pop
);
   import bru_pkg::*;

   localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

   bru_word_type      queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              push;
   bru_word_type      classified;

   always_comb begin
      classified.data = req_word.data_byte;
      if (!req_word.start_req) begin
         classified.kind = KIND_DATA;
      end else if (req_word.data_byte == COPY_FLAG_VALUE) begin
         classified.kind = KIND_START_COPY;
      end else begin
         classified.kind = KIND_START_PACKED;
      end
   end

   assign req_stall  = (fill_ff == FILL_MAX);
   assign push       = req_valid && !req_stall;
   assign word_valid = (fill_ff != '0);
   assign word       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (word_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !word_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (!push && word_pop) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

### rtl/bru_back.sv
// Back end of the unpacker: parses queued words, steps through control codes one a cycle
// while the result is not blocked, and drives the result register. Depends on bru_pkg.
module bru_back #(
   parameter int unsigned COUNT_WIDTH = bru_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [bru_pkg::LENGTH_WIDTH-1:0]    output_length,
   input  logic                                word_valid,
   input  bru_pkg::bru_word_type               word,
   output logic                                word_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bru_pkg::bru_rsp_type                rsp_word
);
   import bru_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [7:0]             shift_ff, shift_in;
   logic [2:0]             left_ff, left_in;
   logic                   pend_run_ff, pend_run_in;
   logic                   wait_ff, wait_in;
   logic [7:0]             lit_ff, lit_in;
   logic [7:0]             run_byte_ff, run_byte_in;
   logic [COUNT_WIDTH-1:0] run_cnt_ff, run_cnt_in;
   logic [1:0]             long_ff, long_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   bru_rsp_type            rsp_word_ff, rsp_word_in;

   logic                   step_ok;
   logic                   emit;
   logic [7:0]             emit_value;
   logic [COUNT_WIDTH-1:0] emit_cnt;
   logic [COUNT_WIDTH-1:0] rem_after;
   logic                   res_en;
   logic [COUNT_WIDTH-1:0] res_rem;
   logic [2:0]             res_left;
   logic [7:0]             res_shift;
   resolve_type            res;
   logic [COUNT_WIDTH+7:0] long_wide;
   logic [COUNT_WIDTH-1:0] long_cnt;
   logic [1:0]             long_next;
   logic [COUNT_WIDTH-1:0] finish_cnt;
   logic [COUNT_WIDTH-1:0] clamp_cnt;

   assign step_ok   = !rsp_valid_ff || !rsp_stall;
   assign word_pop  = step_ok && word_valid && (phase_ff != PH_RUN);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign long_wide  = {run_cnt_ff, word.data};
   assign long_cnt   = (long_wide[COUNT_WIDTH+7:COUNT_WIDTH] != 8'd0) ? '1
                                                                      : long_wide[COUNT_WIDTH-1:0];
   assign long_next  = (long_ff != 2'd0) ? long_ff - 2'd1 : 2'd0;
   assign finish_cnt = (phase_ff == PH_LONG) ? long_cnt : COUNT_WIDTH'(word.data);
   assign clamp_cnt  = (finish_cnt < rem_ff) ? finish_cnt : rem_ff;
   assign res        = bru_resolve(res_rem == '0, res_left, res_shift);

   always_comb begin
      phase_in     = phase_ff;
      shift_in     = shift_ff;
      left_in      = left_ff;
      pend_run_in  = pend_run_ff;
      wait_in      = wait_ff;
      lit_in       = lit_ff;
      run_byte_in  = run_byte_ff;
      run_cnt_in   = run_cnt_ff;
      long_in      = long_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      emit         = 1'b0;
      emit_value   = 8'd0;
      emit_cnt     = COUNT_WIDTH'(1);
      rem_after    = rem_ff - COUNT_WIDTH'(1);
      res_en       = 1'b0;
      res_rem      = rem_after;
      res_left     = left_ff;
      res_shift    = shift_ff;

      if (step_ok && phase_ff == PH_RUN) begin
         emit       = 1'b1;
         emit_value = (shift_ff[1:0] == CODE_ZERO) ? 8'd0 : lit_ff;
         res_en     = 1'b1;
         res_left   = left_ff - 3'd1;
         res_shift  = {2'b00, shift_ff[7:2]};
      end else if (word_pop && word.kind != KIND_DATA) begin
         rem_in      = COUNT_WIDTH'(output_length);
         shift_in    = 8'd0;
         left_in     = 3'd0;
         pend_run_in = 1'b0;
         wait_in     = 1'b0;
         lit_in      = 8'd0;
         run_byte_in = 8'd0;
         run_cnt_in  = '0;
         long_in     = 2'd0;
         if (COUNT_WIDTH'(output_length) == '0) begin
            phase_in = PH_IDLE;
         end else if (word.kind == KIND_START_COPY) begin
            phase_in = PH_COPY;
         end else begin
            phase_in = PH_CTRL;
         end
      end else if (word_pop) begin
         case (phase_ff)
            PH_COPY: begin
               emit       = 1'b1;
               emit_value = word.data;
               if (rem_after == '0) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_CTRL: begin
               shift_in = word.data;
               left_in  = CODES_PER_CTRL;
               if (wait_ff) begin
                  wait_in  = 1'b0;
                  phase_in = pend_run_ff ? PH_VALUE : PH_LIT;
               end else begin
                  res_en    = 1'b1;
                  res_rem   = rem_ff;
                  res_left  = CODES_PER_CTRL;
                  res_shift = word.data;
               end
            end
            PH_LIT: begin
               lit_in     = word.data;
               emit       = 1'b1;
               emit_value = word.data;
               res_en     = 1'b1;
            end
            PH_VALUE: begin
               run_byte_in = word.data;
               phase_in    = PH_LEN;
            end
            PH_LEN: begin
               if (word.data == 8'd0) begin
                  run_cnt_in = '0;
                  long_in    = LONG_LENGTH_BYTES;
                  phase_in   = PH_LONG;
               end else begin
                  run_cnt_in = finish_cnt;
                  emit       = (clamp_cnt != '0);
                  emit_value = run_byte_ff;
                  emit_cnt   = clamp_cnt;
                  rem_after  = rem_ff - clamp_cnt;
                  res_en     = 1'b1;
                  res_rem    = rem_ff - clamp_cnt;
               end
            end
            PH_LONG: begin
               run_cnt_in = long_cnt;
               long_in    = long_next;
               if (long_next == 2'd0) begin
                  emit       = (clamp_cnt != '0);
                  emit_value = run_byte_ff;
                  emit_cnt   = clamp_cnt;
                  rem_after  = rem_ff - clamp_cnt;
                  res_en     = 1'b1;
                  res_rem    = rem_ff - clamp_cnt;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      if (res_en) begin
         phase_in = res.phase;
         left_in  = res.left;
         shift_in = res.shift;
         if (res.take) begin
            pend_run_in = res.pend_run;
            if (res.wait_set) begin
               wait_in = 1'b1;
            end
         end
      end

      if (emit) begin
         rem_in                  = rem_after;
         rsp_valid_in            = 1'b1;
         rsp_word_in.value       = emit_value;
         rsp_word_in.count       = LENGTH_WIDTH'(emit_cnt);
         rsp_word_in.buffer_done = (rem_after == '0);
         rsp_word_in.item_last   = !res_en || (res.phase != PH_RUN);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         shift_ff     <= 8'd0;
         left_ff      <= 3'd0;
         pend_run_ff  <= 1'b0;
         wait_ff      <= 1'b0;
         lit_ff       <= 8'd0;
         run_byte_ff  <= 8'd0;
         run_cnt_ff   <= '0;
         long_ff      <= 2'd0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         shift_ff     <= shift_in;
         left_ff      <= left_in;
         pend_run_ff  <= pend_run_in;
         wait_ff      <= wait_in;
         lit_ff       <= lit_in;
         run_byte_ff  <= run_byte_in;
         run_cnt_ff   <= run_cnt_in;
         long_ff      <= long_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

endmodule
